>>> design/tgarle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; imported by every module of the block.
package tgarle_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int MIN_WIDTH          = 4;
   localparam int CSR_ADDR_BITS      = 5;
   localparam int CSR_DATA_BITS      = 32;

   // Register indexes on the configuration port (byte address = 4 * index)
   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_FLIP_HORIZ   = 3'd2,
      REG_TOP_ORIGIN   = 3'd3,
      REG_COMPRESSED   = 3'd4
   } reg_index_type;

   // Byte phase: header (or first color byte when uncompressed), then color bytes
   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_BYTE0  = 3'd1,
      PH_BYTE1  = 3'd2,
      PH_BYTE2  = 3'd3,
      PH_BYTE3  = 3'd4
   } phase_type;

   localparam logic [7:0] RUN_BIAS = 8'd127;

   typedef enum logic {
      ST_ACCEPT  = 1'b0,
      ST_SEGMENT = 1'b1
   } state_type;

   typedef struct packed {
      logic restart;    // configuration written: drop stream state
      logic load_byte;  // take the request byte
      logic emit;       // produce one segment into the output register
   } dp_cmd_type;

   typedef struct packed {
      logic pixel_ready;  // request byte would complete a pixel
      logic seg_final;    // segment computed now is the last for this pixel
   } dp_status_type;

endpackage

>>> design/tga_rle_pixel_decoder.sv
// Decodes 32-bit TGA pixel data, one request byte per cycle while req_stall is low,
// into row segments of one color. In compressed mode each packet starts with a header
// byte. The fourth color byte of a pixel hands the run to a single segment unit that
// produces one segment per cycle while the result register is not blocked (up to 33
// for a 128-pixel run over narrow rows); request input is stalled meanwhile. A write
// to a defined register restarts decoding. Bytes after the last image pixel are taken
// and dropped.
module tga_rle_pixel_decoder #(
   parameter int COORD_BITS = tgarle_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_data_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [15:0]                          rsp_row,
   output logic [15:0]                          rsp_first_column,
   output logic [7:0]                           rsp_pixel_count,
   output logic [31:0]                          rsp_argb_color,
   output logic                                 rsp_image_done,
   output logic                                 rsp_last,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [tgarle_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [tgarle_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [tgarle_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                 pready
);
   import tgarle_pkg::*;

   logic [15:0] width_ff, height_ff;
   logic        flip_ff, top_ff, compressed_ff;

   reg_index_type         reg_idx;
   logic                  wr_en, cfg_write;
   logic [COORD_BITS-1:0] width_bits, height_bits, width_eff, height_eff;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign pready  = 1'b1;
   assign reg_idx = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      cfg_write = 1'b0;
      prdata    = '0;
      unique case (reg_idx)
         REG_IMAGE_WIDTH: begin
            cfg_write = wr_en;
            prdata    = CSR_DATA_BITS'(width_ff);
         end
         REG_IMAGE_HEIGHT: begin
            cfg_write = wr_en;
            prdata    = CSR_DATA_BITS'(height_ff);
         end
         REG_FLIP_HORIZ: begin
            cfg_write = wr_en;
            prdata    = CSR_DATA_BITS'(flip_ff);
         end
         REG_TOP_ORIGIN: begin
            cfg_write = wr_en;
            prdata    = CSR_DATA_BITS'(top_ff);
         end
         REG_COMPRESSED: begin
            cfg_write = wr_en;
            prdata    = CSR_DATA_BITS'(compressed_ff);
         end
         default: begin
            cfg_write = 1'b0;
            prdata    = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= 16'(MIN_WIDTH);
         height_ff     <= 16'd1;
         flip_ff       <= 1'b0;
         top_ff        <= 1'b0;
         compressed_ff <= 1'b1;
      end else if (cfg_write) begin
         unique case (reg_idx)
            REG_IMAGE_WIDTH:  width_ff      <= pwdata[15:0];
            REG_IMAGE_HEIGHT: height_ff     <= pwdata[15:0];
            REG_FLIP_HORIZ:   flip_ff       <= pwdata[0];
            REG_TOP_ORIGIN:   top_ff        <= pwdata[0];
            REG_COMPRESSED:   compressed_ff <= pwdata[0];
            default:          compressed_ff <= compressed_ff;
         endcase
      end
   end

   // Degenerate sizes: narrow widths act as the minimum, zero height as one row
   assign width_bits  = width_ff[COORD_BITS-1:0];
   assign height_bits = height_ff[COORD_BITS-1:0];
   assign width_eff   = (width_bits < COORD_BITS'(MIN_WIDTH)) ? COORD_BITS'(MIN_WIDTH)
                                                              : width_bits;
   assign height_eff  = (height_bits == '0) ? COORD_BITS'(1) : height_bits;

   tgarle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cfg_write (cfg_write),
      .status    (status),
      .cmd       (cmd)
   );

   tgarle_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .data_byte       (req_data_byte),
      .width_eff       (width_eff),
      .height_eff      (height_eff),
      .flip_horizontal (flip_ff),
      .top_origin      (top_ff),
      .compressed      (compressed_ff),
      .row             (rsp_row),
      .first_column    (rsp_first_column),
      .pixel_count     (rsp_pixel_count),
      .argb_color      (rsp_argb_color),
      .image_done      (rsp_image_done),
      .last            (rsp_last)
   );

endmodule

>>> design/tgarle_ctrl.sv
// Controller for the TGA run-length pixel decoder: accept / segment state machine
// and the result-valid flag. Depends on tgarle_pkg.
module tgarle_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic                     cfg_write,
   input  tgarle_pkg::dp_status_type status,
   output tgarle_pkg::dp_cmd_type    cmd
);
   import tgarle_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_ACCEPT);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.restart   = cfg_write;
      cmd.load_byte = 1'b0;
      cmd.emit      = 1'b0;
      unique case (state_ff)
         ST_ACCEPT: begin
            cmd.load_byte = req_valid;
            if (req_valid && status.pixel_ready) begin
               state_in = ST_SEGMENT;
            end
         end
         ST_SEGMENT: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               if (status.seg_final) begin
                  state_in = ST_ACCEPT;
               end
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
      if (cfg_write) begin
         state_in = ST_ACCEPT;
      end
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   a_pixel_starts_segments: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCEPT && req_valid && status.pixel_ready && !cfg_write)
      |=> state_ff == ST_SEGMENT)
      else $error("completed pixel did not start segment output");

   a_final_segment_returns: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.seg_final && !cfg_write) |=> state_ff == ST_ACCEPT)
      else $error("final segment did not return to byte accept");

   a_blocked_output_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEGMENT && !slot_free && !cfg_write)
      |=> state_ff == ST_SEGMENT && rsp_valid_ff)
      else $error("segment state left while output register was blocked");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted segment not presented");

endmodule

>>> design/tgarle_dp.sv
// Datapath for the TGA run-length pixel decoder: packet header and color byte
// capture, position tracking and row segment generation. Depends on tgarle_pkg.
module tgarle_dp #(
   parameter int COORD_BITS = tgarle_pkg::COORD_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tgarle_pkg::dp_cmd_type    cmd,
   output tgarle_pkg::dp_status_type status,
   input  logic [7:0]                data_byte,
   input  logic [COORD_BITS-1:0]     width_eff,
   input  logic [COORD_BITS-1:0]     height_eff,
   input  logic                      flip_horizontal,
   input  logic                      top_origin,
   input  logic                      compressed,
   output logic [15:0]               row,
   output logic [15:0]               first_column,
   output logic [7:0]                pixel_count,
   output logic [31:0]               argb_color,
   output logic                      image_done,
   output logic                      last
);
   import tgarle_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [7:0]            packet_left_ff, packet_left_in;
   logic                  raw_ff, raw_in;
   logic [23:0]           color_bytes_ff, color_bytes_in;
   logic [31:0]           color_ff, color_in;
   logic [7:0]            remain_ff, remain_in;
   logic [COORD_BITS-1:0] column_ff, column_in;
   logic [COORD_BITS-1:0] row_count_ff, row_count_in;
   logic                  finished_ff, finished_in;

   logic [15:0] row_ff, column_out_ff;
   logic [7:0]  count_ff;
   logic [31:0] argb_ff;
   logic        done_ff, last_ff;

   logic                  is_header;
   logic [1:0]            byte_k;
   logic [7:0]            left_dec;
   logic [COORD_BITS-1:0] cols_left;
   logic                  row_fits;
   logic [7:0]            seg;
   logic                  full_row;
   logic                  finishing;
   logic [COORD_BITS-1:0] mrow, mcol;

   assign is_header = compressed && (phase_ff == PH_HEADER);
   assign byte_k    = (phase_ff == PH_HEADER) ? 2'd0 : 2'(phase_ff - PH_BYTE0);
   assign left_dec  = (packet_left_ff != 8'd0) ? packet_left_ff - 8'd1 : 8'd0;

   // Segment: min(columns left in row, pixels left in run)
   assign cols_left = width_eff - column_ff;
   assign row_fits  = cols_left <= COORD_BITS'(remain_ff);
   assign seg       = row_fits ? 8'(cols_left) : remain_ff;
   assign full_row  = row_fits;
   assign finishing = full_row && (row_count_ff == height_eff - COORD_BITS'(1));
   assign mrow      = top_origin ? row_count_ff : height_eff - COORD_BITS'(1) - row_count_ff;
   assign mcol      = flip_horizontal ? cols_left - COORD_BITS'(seg) : column_ff;

   assign status.pixel_ready = !finished_ff && !is_header && (byte_k == 2'd3);
   assign status.seg_final   = finishing || (cols_left >= COORD_BITS'(remain_ff));

   always_comb begin
      phase_in       = phase_ff;
      packet_left_in = packet_left_ff;
      raw_in         = raw_ff;
      color_bytes_in = color_bytes_ff;
      color_in       = color_ff;
      remain_in      = remain_ff;
      column_in      = column_ff;
      row_count_in   = row_count_ff;
      finished_in    = finished_ff;

      if (cmd.restart) begin
         phase_in       = PH_HEADER;
         packet_left_in = 8'd0;
         raw_in         = 1'b0;
         color_bytes_in = 24'd0;
         column_in      = '0;
         row_count_in   = '0;
         finished_in    = 1'b0;
      end else if (cmd.load_byte && !finished_ff) begin
         if (is_header) begin
            if (!data_byte[7]) begin
               packet_left_in = data_byte + 8'd1;
               raw_in         = 1'b1;
            end else begin
               packet_left_in = data_byte - RUN_BIAS;
               raw_in         = 1'b0;
            end
            phase_in = PH_BYTE0;
         end else if (byte_k != 2'd3) begin
            unique case (byte_k)
               2'd0:    color_bytes_in[7:0]   = data_byte;
               2'd1:    color_bytes_in[15:8]  = data_byte;
               default: color_bytes_in[23:16] = data_byte;
            endcase
            phase_in = phase_type'(3'(byte_k) + 3'd2);
         end else begin
            color_in = {data_byte, color_bytes_ff};
            if (!compressed) begin
               remain_in = 8'd1;
               phase_in  = PH_HEADER;
            end else if (raw_ff) begin
               remain_in      = 8'd1;
               packet_left_in = left_dec;
               phase_in       = (left_dec != 8'd0) ? PH_BYTE0 : PH_HEADER;
            end else begin
               remain_in      = (packet_left_ff != 8'd0) ? packet_left_ff : 8'd1;
               packet_left_in = 8'd0;
               phase_in       = PH_HEADER;
            end
         end
      end else if (cmd.emit) begin
         remain_in = remain_ff - seg;
         if (full_row) begin
            column_in    = '0;
            row_count_in = row_count_ff + COORD_BITS'(1);
            finished_in  = finishing;
         end else begin
            column_in = column_ff + COORD_BITS'(seg);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         packet_left_ff <= 8'd0;
         raw_ff         <= 1'b0;
         color_bytes_ff <= 24'd0;
         column_ff      <= '0;
         row_count_ff   <= '0;
         finished_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         packet_left_ff <= packet_left_in;
         raw_ff         <= raw_in;
         color_bytes_ff <= color_bytes_in;
         column_ff      <= column_in;
         row_count_ff   <= row_count_in;
         finished_ff    <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff  <= color_in;
      remain_ff <= remain_in;
      if (cmd.emit) begin
         row_ff        <= 16'(mrow);
         column_out_ff <= 16'(mcol);
         count_ff      <= seg;
         argb_ff       <= color_ff;
         done_ff       <= finishing;
         last_ff       <= status.seg_final;
      end
   end

   assign row          = row_ff;
   assign first_column = column_out_ff;
   assign pixel_count  = count_ff;
   assign argb_color   = argb_ff;
   assign image_done   = done_ff;
   assign last         = last_ff;

endmodule

>>> sim/tga_rle_pixel_decoder_test.sv
// Self-checking testbench for tga_rle_pixel_decoder: TGA pixel-data byte streams in,
// row segments out, each checked against an in-bench decoder model.
// Depends on design/tgarle_pkg.sv and design/tga_rle_pixel_decoder.sv.
module tga_rle_pixel_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tgarle_pkg::*;

   localparam int UNUSED_REG_INDEX = 7;
   localparam int HOLD_CYCLES      = 400;
   localparam int SETTLE_CYCLES    = 50;
   localparam int RANDOM_ITEMS     = 460;

   typedef struct packed {
      logic [15:0] row;
      logic [15:0] first_column;
      logic [7:0]  pixel_count;
      logic [31:0] argb_color;
      logic        image_done;
      logic        last;
   } segment_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_data_byte = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [15:0]              rsp_row;
   logic [15:0]              rsp_first_column;
   logic [7:0]               rsp_pixel_count;
   logic [31:0]              rsp_argb_color;
   logic                     rsp_image_done;
   logic                     rsp_last;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // decoder model: configuration
   logic [15:0] img_width = 16'd4;
   logic [15:0] img_height = 16'd1;
   bit          mirror_columns = 1'b0;
   bit          rows_top_first = 1'b0;
   bit          rle_mode = 1'b1;

   // decoder model: stream position
   phase_type   phase = PH_HEADER;
   logic [7:0]  packet_left = '0;
   bit          raw_packet = 1'b0;
   logic [23:0] color_low = '0;
   int unsigned column_pos = 0;
   int unsigned row_pos = 0;
   bit          image_finished = 1'b0;

   segment_type expected_segments[$];
   logic [7:0]  image_bytes[$];
   logic [7:0]  pending_bytes[$];
   segment_type seg_want;

   int bytes_queued = 0;
   int bytes_accepted = 0;
   int errors = 0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   int holds_requested = 0;
   int holds_served = 0;
   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;

   tga_rle_pixel_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row          (rsp_row),
      .rsp_first_column (rsp_first_column),
      .rsp_pixel_count  (rsp_pixel_count),
      .rsp_argb_color   (rsp_argb_color),
      .rsp_image_done   (rsp_image_done),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void restart_stream();
      phase = PH_HEADER;
      packet_left = '0;
      raw_packet = 1'b0;
      color_low = '0;
      column_pos = 0;
      row_pos = 0;
      image_finished = 1'b0;
   endfunction

   function automatic void apply_register(input int index, input logic [31:0] value);
      case (index)
         REG_IMAGE_WIDTH:  img_width = value[15:0];
         REG_IMAGE_HEIGHT: img_height = value[15:0];
         REG_FLIP_HORIZ:   mirror_columns = value[0];
         REG_TOP_ORIGIN:   rows_top_first = value[0];
         REG_COMPRESSED:   rle_mode = value[0];
         default:          return;
      endcase
      restart_stream();
   endfunction

   // Advance the model by one request byte; queue the segments it produces.
   function automatic void decode_byte(input logic [7:0] b);
      int unsigned k, w, h, remain, seg;
      logic [31:0] color;
      segment_type s, held;
      bit          have_held;
      have_held = 1'b0;
      if (image_finished) return;
      if (rle_mode && phase == PH_HEADER) begin
         raw_packet = (b <= RUN_BIAS);
         packet_left = raw_packet ? b + 8'd1 : b - RUN_BIAS;
         phase = PH_BYTE0;
         return;
      end
      k = (phase == PH_HEADER) ? 0 : (phase - 1) & 3;
      if (k < 3) begin
         color_low[8*k +: 8] = b;
         phase = phase_type'(k + 2);
         return;
      end
      color = {b, color_low};
      if (!rle_mode) begin
         remain = 1;
         phase = PH_HEADER;
      end else if (raw_packet) begin
         remain = 1;
         if (packet_left != 0) packet_left--;
         phase = (packet_left != 0) ? PH_BYTE0 : PH_HEADER;
      end else begin
         remain = (packet_left != 0) ? packet_left : 1;
         packet_left = '0;
         phase = PH_HEADER;
      end
      w = (img_width < MIN_WIDTH) ? MIN_WIDTH : img_width;
      h = (img_height == 0) ? 1 : img_height;
      // split at row ends, stop at the last pixel of the image
      while (remain > 0 && !image_finished) begin
         seg = w - column_pos;
         if (seg > remain) seg = remain;
         s.row = 16'(rows_top_first ? row_pos : h - 1 - row_pos);
         s.first_column = 16'(mirror_columns ? w - column_pos - seg : column_pos);
         s.pixel_count = 8'(seg);
         s.argb_color = color;
         s.last = 1'b0;
         remain -= seg;
         column_pos += seg;
         if (column_pos >= w) begin
            column_pos = 0;
            row_pos++;
            if (row_pos >= h) image_finished = 1'b1;
         end
         s.image_done = image_finished;
         if (have_held) expected_segments.push_back(held);
         held = s;
         have_held = 1'b1;
      end
      if (have_held) begin
         held.last = 1'b1;
         expected_segments.push_back(held);
      end
   endfunction

   function automatic void queue_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endfunction

   // Well-formed pixel data for the current image; returns the bytes made before
   // the image ends or the budget runs out. Up to three ignored bytes follow a full image.
   function automatic int build_image(input int budget, input bit long_runs);
      int w, h, n, colors, made, cap;
      longint pixels_left;
      made = 0;
      w = (img_width < MIN_WIDTH) ? MIN_WIDTH : img_width;
      h = (img_height == 0) ? 1 : img_height;
      cap = (2 * w > 128) ? 128 : 2 * w;
      pixels_left = longint'(w) * longint'(h);
      while (pixels_left > 0 && made < budget) begin
         if (!rle_mode) begin
            n = 1;
            colors = 1;
         end else if (!long_runs && $urandom_range(0, 9) < 4) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
            image_bytes.push_back(8'(n - 1));
            made++;
            // long raw packets are cut off where the budget ends
            if (n > (budget - made) / 4 + 1) n = (budget - made) / 4 + 1;
            colors = n;
         end else begin
            if (long_runs) n = $urandom_range(96, 128);
            else if ($urandom_range(0, 3) == 0) n = $urandom_range(1, 128);
            else n = $urandom_range(1, cap);
            image_bytes.push_back(8'(n + 127));
            made++;
            colors = 1;
         end
         repeat (4 * colors) begin
            image_bytes.push_back(8'($urandom_range(0, 255)));
            made++;
         end
         pixels_left = (n >= pixels_left) ? 0 : pixels_left - n;
      end
      if (pixels_left == 0)
         repeat ($urandom_range(0, 3)) image_bytes.push_back(8'($urandom_range(0, 255)));
      return made;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   task automatic feed_bytes(input int count);
      repeat (count) queue_byte(image_bytes.pop_front());
   endtask

   task automatic wait_idle();
      while (bytes_accepted != bytes_queued || expected_segments.size() != 0)
         @(negedge clock);
      // header and ignored bytes produce nothing; give the block time to finish them
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input int index, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_BITS'(4 * index);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (!pready) @(negedge clock);
      @(posedge clock);
      apply_register(index, value);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_data_byte);
            bytes_accepted <= bytes_accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               req_valid <= 1'b1;
               req_data_byte <= pending_bytes.pop_front();
               send_gap <= send_idle_on ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result back-pressure, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
      end else if (holds_served != holds_requested) begin
         holds_served <= holds_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= (recv_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end
   end

   // segment checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_segments.size() == 0) begin
            $display("%0t: unexpected segment row %0h column %0h count %0h color %0h",
                     $time, rsp_row, rsp_first_column, rsp_pixel_count, rsp_argb_color);
            errors++;
         end else begin
            seg_want = expected_segments.pop_front();
            check_field("row", 32'(seg_want.row), 32'(rsp_row));
            check_field("first_column", 32'(seg_want.first_column),
                        32'(rsp_first_column));
            check_field("pixel_count", 32'(seg_want.pixel_count), 32'(rsp_pixel_count));
            check_field("argb_color", seg_want.argb_color, rsp_argb_color);
            check_field("image_done", 32'(seg_want.image_done), 32'(rsp_image_done));
            check_field("last", 32'(seg_want.last), 32'(rsp_last));
         end
      end
   end

   initial begin
      int          phase_no, random_items, r;
      bit          long_runs, write_all;
      logic [15:0] new_width, new_height;
      bit          new_flip, new_top, new_rle;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset image is 4x1: a one-pixel run, then a raw packet overrunning the image
      queue_byte(8'h80);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(8'h5A);
      queue_byte(8'hA5);
      queue_byte(8'h7F);
      for (int i = 0; i < 12; i++) queue_byte(8'(37 * i + 3));
      queue_byte(8'h00);
      wait_idle();

      // undersized width and zero height, mirrored, top first; a 128 run gets cut
      csr_write(REG_IMAGE_WIDTH, 32'd3);
      csr_write(REG_IMAGE_HEIGHT, 32'd0);
      csr_write(REG_FLIP_HORIZ, 32'd1);
      csr_write(REG_TOP_ORIGIN, 32'd1);
      queue_byte(8'hFF);
      queue_byte(8'hC3);
      queue_byte(8'h3C);
      queue_byte(8'hFF);
      queue_byte(8'h00);
      wait_idle();

      phase_no = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         long_runs = (phase_no == 1);
         case (phase_no)
            0: begin
               new_width = 16'hFFFF;
               new_height = 16'hFFFF;
               new_flip = 1'b1;
               new_top = 1'b0;
               new_rle = 1'b1;
            end
            1: begin
               new_width = 16'd4;
               new_height = 16'hFFFF;
               new_flip = 1'b0;
               new_top = 1'b1;
               new_rle = 1'b1;
            end
            2: begin
               new_width = 16'($urandom_range(4, 8));
               new_height = 16'($urandom_range(1, 3));
               new_flip = 1'($urandom_range(0, 1));
               new_top = 1'($urandom_range(0, 1));
               new_rle = 1'b0;
            end
            default: begin
               r = $urandom_range(0, 9);
               new_width = (r == 0) ? 16'($urandom_range(0, 3)) :
                           (r == 1) ? 16'hFFFF : 16'($urandom_range(4, 10));
               r = $urandom_range(0, 9);
               new_height = (r == 0) ? 16'd0 :
                            (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 4));
               new_flip = 1'($urandom_range(0, 1));
               new_top = 1'($urandom_range(0, 1));
               new_rle = ($urandom_range(0, 3) != 0);
            end
         endcase
         write_all = (phase_no < 3) || ($urandom_range(0, 1) == 1);
         if (write_all || $urandom_range(0, 1))
            csr_write(REG_IMAGE_WIDTH, {16'($urandom), new_width});
         if (write_all || $urandom_range(0, 1))
            csr_write(REG_IMAGE_HEIGHT, {16'($urandom), new_height});
         if (write_all || $urandom_range(0, 1))
            csr_write(REG_FLIP_HORIZ, {31'($urandom), new_flip});
         if (write_all || $urandom_range(0, 1))
            csr_write(REG_TOP_ORIGIN, {31'($urandom), new_top});
         // always written, so every image starts from a restarted stream
         csr_write(REG_COMPRESSED, {31'($urandom), new_rle});

         send_idle_on = long_runs ? 1'b0 : ($urandom_range(0, 3) != 0);
         recv_idle_on = ($urandom_range(0, 3) != 0);
         if (phase_no > 2 && $urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(15, 30)) begin
               image_bytes.push_back(8'($urandom_range(0, 255)));
               random_items++;
            end
         end else begin
            random_items += build_image(rle_mode ? 50 : 70, long_runs);
         end

         // long receiver hold-off while the sender keeps pushing runs
         if (long_runs) holds_requested++;
         if (phase_no % 4 == 3) begin
            feed_bytes(image_bytes.size() / 2);
            wait_idle();
            if (phase_no % 8 == 3) csr_write(UNUSED_REG_INDEX, $urandom);
         end
         feed_bytes(image_bytes.size());
         wait_idle();
         phase_no++;
      end

      if (errors == 0 && expected_segments.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> sim.f
design/tgarle_pkg.sv
design/tgarle_ctrl.sv
design/tgarle_dp.sv
design/tga_rle_pixel_decoder.sv
sim/tga_rle_pixel_decoder_test.sv
